// ===== rtl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary edge detect package
// Frame geometry, derived counter widths, levels and the position record
// that passes from the position counters to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

    // Frame side in pixels; the frame is square.
    localparam int IMAGE_SIDE = 256;

    // Column counters index the line store directly.
    localparam int COL_W = $clog2(IMAGE_SIDE);
    // The input row runs up to two past the last pixel row during the flush part.
    localparam int ROW_W = $clog2(IMAGE_SIDE + 2);

    localparam logic [7:0] WHITE_LEVEL     = 8'd255;
    localparam logic [7:0] BLACK_LEVEL     = 8'd0;
    localparam logic [7:0] THRESHOLD_RESET = 8'd128;

    // Position facts about the item currently offered at the input.
    typedef struct packed {
        logic live;    // item lies in the pixel part of the frame
        logic emit;    // item yields a result pixel
        logic border;  // that result pixel lies on the frame border
        logic last;    // that result pixel is the last of the frame
    } t_pos_info;

endpackage

`default_nettype wire

// ===== rtl/bed_pos.sv =====
// ----------------------------------------------------------------------------
// Binary edge detect position counters
// Tracks the input item position and the output pixel position within the
// frame and reports what the next item means for the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_pos (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    output logic [bed_pkg::COL_W-1:0]        o_col,
    output bed_pkg::t_pos_info               o_info
);

    logic [bed_pkg::ROW_W-1:0] r_in_row,  n_in_row;
    logic [bed_pkg::COL_W-1:0] r_in_col,  n_in_col;
    logic [bed_pkg::COL_W-1:0] r_out_row, n_out_row;
    logic [bed_pkg::COL_W-1:0] r_out_col, n_out_col;

    localparam logic [bed_pkg::COL_W-1:0] LAST_IDX = bed_pkg::COL_W'(bed_pkg::IMAGE_SIDE - 1);
    localparam logic [bed_pkg::ROW_W-1:0] SIDE_ROW = bed_pkg::ROW_W'(bed_pkg::IMAGE_SIDE);

    // Classify the item at the current position.
    always_comb begin
        o_col         = r_in_col;
        o_info.live   = (r_in_row < SIDE_ROW);
        o_info.emit   = (r_in_row >= bed_pkg::ROW_W'(2)) ||
                        ((r_in_row == bed_pkg::ROW_W'(1)) && (r_in_col != '0));
        o_info.border = (r_out_row == '0) || (r_out_row == LAST_IDX) ||
                        (r_out_col == '0) || (r_out_col == LAST_IDX);
        o_info.last   = (r_out_row == LAST_IDX) && (r_out_col == LAST_IDX);
    end

    // Next position after the current item; the last pixel restarts the frame.
    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (o_info.emit && o_info.last) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
        end else begin
            if (o_info.emit) begin
                if (r_out_col == LAST_IDX) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
            if (r_in_col == LAST_IDX) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end
    end

    // Counters advance once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (i_adv) begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    // The last output pixel must bring every counter back to the frame start.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_info.emit && o_info.last |=>
            (r_in_row == '0) && (r_in_col == '0) && (r_out_row == '0) && (r_out_col == '0))
        else $error("counters not cleared after last pixel");

    // Output column only moves on items that produce a pixel.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !o_info.emit |=> $stable(r_out_col) && $stable(r_out_row))
        else $error("output position moved without a result");

    // Results never start before the second row of input.
    a_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_info.emit |-> (r_in_row != '0))
        else $error("result during first input row");

endmodule

`default_nettype wire

// ===== rtl/binary_edge_detect.sv =====
// ----------------------------------------------------------------------------
// Binary edge detect
// Thresholds a square grey frame in raster order and marks black pixels that
// touch a white 4-neighbour as edges; border pixels keep their thresholded
// level. A one-bit two-row line store feeds a 3x3 bit window.
//
//   Channel | Signals                                      | Direction
//   --------+----------------------------------------------+----------
//   in      | i_in_valid, o_in_stall, i_pixel_in, i_flush  | sink
//   out     | o_out_valid, i_out_stall, o_pixel_out,       | source
//           | o_frame_end                                  |
//   cfg     | i_cfg_we, i_cfg_data (threshold)             | sink
//
// One transaction per clock is taken unless an output stall backs up; a result
// passes through the middle stage registers and then the output register.
// The line store is a 2-bit wide synchronous RAM read at acceptance and written
// back as the middle stage moves on; that read-modify-write loop sets the rate.
// Synchronous active-low reset clears counters, window and valid flags and
// sets the threshold to 128; the line store is not cleared.
// An output stall holds the result register and backs up into the input
// only when the middle stage holds a transaction that has a result.
// Output lags input by one row plus one pixel, so each frame is followed
// by IMAGE_SIDE+1 flush transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_edge_detect (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Input channel
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [7:0] i_pixel_in,
    input  wire        i_flush,
    // Output channel
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_pixel_out,
    output logic       o_frame_end,
    // Configuration
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data
);

    logic [7:0]                 r_threshold;
    logic                       accept;
    logic                       s0_newbit;
    logic [bed_pkg::COL_W-1:0]  s0_col;
    bed_pkg::t_pos_info         s0_info;

    logic                       r_s1_valid;
    logic                       r_s1_newbit;
    logic [bed_pkg::COL_W-1:0]  r_s1_col;
    bed_pkg::t_pos_info         r_s1_info;
    logic [1:0]                 r_rd;       // [1] upper row bit, [0] middle row bit
    logic                       s1_go;

    logic [8:0]                 r_window, n_window;
    logic [7:0]                 n_pixel;
    logic                       out_free;
    logic                       r_out_valid;
    logic [7:0]                 r_pixel_out;
    logic                       r_frame_end;

    // Line store: bit 1 holds the row two back, bit 0 the row one back.
    logic [1:0]                 r_line_mem [bed_pkg::IMAGE_SIDE];

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= bed_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Handshake: the middle stage moves on unless its result has nowhere to go.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!r_s1_info.emit || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign accept     = i_in_valid && !o_in_stall;

    bed_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (accept),
        .o_col   (s0_col),
        .o_info  (s0_info)
    );

    // Threshold the incoming pixel; flushes and the flush part count as black.
    assign s0_newbit = !i_flush && s0_info.live && (i_pixel_in >= r_threshold);

    // Line store read on acceptance, registered read data. A write-back to the
    // same column in the same cycle (frame restart) is forwarded.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (s1_go && (r_s1_col == s0_col)) begin
                r_rd <= {r_rd[0], r_s1_newbit};
            end else begin
                r_rd <= r_line_mem[s0_col];
            end
        end
    end

    // Line store write-back as the middle stage moves on.
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_line_mem[r_s1_col] <= {r_rd[0], r_s1_newbit};
        end
    end

    // Middle stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_newbit <= s0_newbit;
            r_s1_col    <= s0_col;
            r_s1_info   <= s0_info;
        end
    end

    // Window shift and edge decision on the shifted window.
    always_comb begin
        n_window = {r_s1_newbit, r_rd[0], r_rd[1], r_window[8:3]};
        if (r_s1_info.border) begin
            n_pixel = n_window[4] ? bed_pkg::WHITE_LEVEL : bed_pkg::BLACK_LEVEL;
        end else if (!n_window[4] &&
                     (n_window[3] || n_window[5] || n_window[1] || n_window[7])) begin
            n_pixel = bed_pkg::BLACK_LEVEL;
        end else begin
            n_pixel = bed_pkg::WHITE_LEVEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (s1_go) begin
            r_window <= n_window;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_info.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_info.emit) begin
            r_pixel_out <= n_pixel;
            r_frame_end <= r_s1_info.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_frame_end = r_frame_end;

    // A transaction with no result never holds up the pipeline.
    a_no_result_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_info.emit |-> s1_go)
        else $error("resultless transaction stalled");

    // Input is stalled only behind a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_s1_info.emit && r_out_valid && i_out_stall)
        else $error("input stalled without cause");

    // Result pixels are pure black or pure white.
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_out == bed_pkg::BLACK_LEVEL) ||
                        (o_pixel_out == bed_pkg::WHITE_LEVEL))
        else $error("result pixel not binary");

    // A result leaving the middle stage always lands in the output register.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_info.emit |=> o_out_valid)
        else $error("result lost");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Binary edge detect testbench
// Streams the opening rows of a grey frame into the edge detector and checks
// every result pixel against a bit-accurate predictor held in the testbench.
// The threshold moves between phases. Both channels idle at random, and the
// receiver holds off once for a long stretch so that the block backs up into
// its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXELS         = bed_pkg::IMAGE_SIDE * bed_pkg::IMAGE_SIDE;
    localparam int FRAME_ITEMS    = bed_pkg::IMAGE_SIDE * (bed_pkg::IMAGE_SIDE + 1) + 1;
    localparam int IDLE_PCT       = 12;
    localparam int HOLD_AT        = 380;
    localparam int HOLD_CYCLES    = 200;
    localparam int QUIET_LO       = 150;
    localparam int QUIET_HI       = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_COUNT      = 20;

    // Directed opening: level extremes around the reset threshold and flush
    // transactions placed inside the pixel part of the frame.
    localparam logic [7:0] DIR_GREY [DIR_COUNT] = '{
        8'd0, 8'd255, 8'd127, 8'd128, 8'd129, 8'd1, 8'd254, 8'd128, 8'd255, 8'd0,
        8'hAA, 8'h55, 8'd128, 8'd127, 8'd255, 8'd255, 8'd0, 8'd128, 8'd64, 8'd192
    };
    localparam logic [DIR_COUNT-1:0] DIR_FLUSH = 20'b0000_1000_0100_1001_0000;

    typedef struct {
        logic [7:0] grey;
        logic       flush;
    } t_grey_item;

    typedef struct {
        logic [7:0] level;
        logic       frame_end;
    } t_edge_pixel;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] in_grey       = 8'd0;
    logic       in_flush      = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [7:0] out_level;
    logic       out_frame_end;
    logic       cfg_we        = 1'b0;
    logic [7:0] cfg_data      = 8'd0;

    t_grey_item  pixel_stream_q[$];
    t_edge_pixel edge_results_due[$];

    logic in_fire    = 1'b0;
    int   accepted_items = 0;
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    logic quiet;

    // Generator position within the frame's transaction stream.
    int         gen_pos   = 0;
    logic [7:0] run_level = 8'd0;

    // Predictor state.
    logic [7:0]                thr_level = bed_pkg::THRESHOLD_RESET;
    logic                      upper_bits  [bed_pkg::IMAGE_SIDE] = '{default: 1'b0};
    logic                      middle_bits [bed_pkg::IMAGE_SIDE] = '{default: 1'b0};
    logic [8:0]                win_bits  = '0;
    logic [bed_pkg::ROW_W-1:0] in_row_q  = '0;
    logic [bed_pkg::COL_W-1:0] in_col_q  = '0;
    logic [bed_pkg::COL_W-1:0] out_row_q = '0;
    logic [bed_pkg::COL_W-1:0] out_col_q = '0;

    assign quiet = (accepted_items >= QUIET_LO) && (accepted_items < QUIET_HI);

    binary_edge_detect dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_pixel_in  (in_grey),
        .i_flush     (in_flush),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_pixel_out (out_level),
        .o_frame_end (out_frame_end),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advances the predicted window by one transaction and queues the edge
    // pixel that it yields, if any.
    task automatic predict_edge_pixel(input logic [7:0] grey, input logic flush);
        logic        new_bit;
        logic        up_bit;
        logic        mid_bit;
        logic        centre;
        logic        any_white;
        logic        border;
        logic        last_px;
        t_edge_pixel res;
        new_bit = (!flush && in_row_q < bed_pkg::IMAGE_SIDE) ? (grey >= thr_level) : 1'b0;
        up_bit  = upper_bits[in_col_q];
        mid_bit = middle_bits[in_col_q];
        upper_bits[in_col_q]  = mid_bit;
        middle_bits[in_col_q] = new_bit;
        // Newest column enters at the top; the centre pixel sits in the middle column.
        win_bits = {new_bit, mid_bit, up_bit, win_bits[8:3]};
        if (in_row_q >= 2 || (in_row_q == 1 && in_col_q >= 1)) begin
            centre    = win_bits[4];
            any_white = win_bits[3] | win_bits[5] | win_bits[1] | win_bits[7];
            border    = out_row_q == 0 || out_row_q == bed_pkg::IMAGE_SIDE - 1 ||
                        out_col_q == 0 || out_col_q == bed_pkg::IMAGE_SIDE - 1;
            last_px   = out_row_q == bed_pkg::IMAGE_SIDE - 1 &&
                        out_col_q == bed_pkg::IMAGE_SIDE - 1;
            if (border) begin
                res.level = centre ? bed_pkg::WHITE_LEVEL : bed_pkg::BLACK_LEVEL;
            end else begin
                res.level = (!centre && any_white) ? bed_pkg::BLACK_LEVEL
                                                   : bed_pkg::WHITE_LEVEL;
            end
            res.frame_end = last_px;
            edge_results_due.push_back(res);
            // The last pixel restarts every counter; stores and window persist.
            if (last_px) begin
                out_row_q = '0;
                out_col_q = '0;
                in_row_q  = '0;
                in_col_q  = '0;
                return;
            end
            if (out_col_q == bed_pkg::IMAGE_SIDE - 1) begin
                out_col_q = '0;
                out_row_q = out_row_q + 1'b1;
            end else begin
                out_col_q = out_col_q + 1'b1;
            end
        end
        if (in_col_q == bed_pkg::IMAGE_SIDE - 1) begin
            in_col_q = '0;
            in_row_q = in_row_q + 1'b1;
        end else begin
            in_col_q = in_col_q + 1'b1;
        end
    endtask

    task automatic push_item(input logic [7:0] grey, input logic flush);
        t_grey_item it;
        it.grey  = grey;
        it.flush = flush;
        pixel_stream_q.push_back(it);
        gen_pos = (gen_pos == FRAME_ITEMS - 1) ? 0 : gen_pos + 1;
    endtask

    // Pixel part: runs of one level with scattered noise and rare flushes.
    // Flush part: mostly flushes, with the odd stray pixel that must be ignored.
    task automatic push_random(input int count);
        logic [7:0] grey;
        logic       flush;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(7) == 0) begin
                run_level = 8'($urandom_range(255));
            end
            if (gen_pos < PIXELS) begin
                flush = ($urandom_range(49) == 0);
                grey  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : run_level;
            end else begin
                flush = ($urandom_range(19) != 0);
                grey  = 8'($urandom_range(255));
            end
            push_item(grey, flush);
        end
    endtask

    // Writes the threshold once the block has drained and settled.
    task automatic set_threshold(input logic [7:0] level);
        while (pixel_stream_q.size() > 0 || in_valid || edge_results_due.size() > 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_data  <= level;
        thr_level = level;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Input driver: offers the next pending transaction once the current one
    // has been taken, sometimes idling instead.
    always @(negedge clk) begin : driver
        t_grey_item it;
        if (!in_valid || in_fire) begin
            if (rst_n && pixel_stream_q.size() > 0 &&
                !(!quiet && $urandom_range(99) < IDLE_PCT)) begin
                it = pixel_stream_q.pop_front();
                in_valid <= 1'b1;
                in_grey  <= it.grey;
                in_flush <= it.flush;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off part way through.
    always @(negedge clk) begin : receiver
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && accepted_items >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: predicts on every accepted input transaction, checks every
    // accepted result and watches for a stalled run.
    always @(posedge clk) begin : monitor
        t_edge_pixel due;
        logic        in_take;
        logic        out_take;
        in_take  = rst_n && in_valid && !in_stall;
        out_take = rst_n && out_valid && !out_stall;
        in_fire <= in_take;
        if (in_take) begin
            predict_edge_pixel(in_grey, in_flush);
            accepted_items <= accepted_items + 1;
        end
        if (out_take) begin
            if (edge_results_due.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("Unexpected edge result: level %0d frame_end %0b",
                             out_level, out_frame_end);
                end
                fail_count++;
            end else begin
                due = edge_results_due.pop_front();
                if (out_level !== due.level || out_frame_end !== due.frame_end) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display({"Edge result mismatch: expected level %0d frame_end %0b,",
                                  " got level %0d frame_end %0b"},
                                 due.level, due.frame_end, out_level, out_frame_end);
                    end
                    fail_count++;
                end
            end
        end
        if (!rst_n || in_take || out_take) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence, one threshold setting per phase.
    initial begin : stimulus
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening rows under the reset threshold.
        for (int k = 0; k < DIR_COUNT; k++) begin
            push_item(DIR_GREY[k], DIR_FLUSH[k]);
        end
        push_random(180);

        // Threshold extremes: everything white, then almost everything black.
        set_threshold(8'd0);
        push_random(90);
        set_threshold(8'd255);
        push_random(80);

        // A random threshold; the long hold-off falls here.
        set_threshold(8'($urandom_range(1, 254)));
        push_random(80);

        while (pixel_stream_q.size() > 0 || in_valid || edge_results_due.size() > 0) begin
            @(posedge clk);
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
